### rtl/iyts_pkg.sv
// shared types and constants for the imu yaw tare and staleness monitor
package iyts_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DEGRADE_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESTORE_TIME    = 1'd1;

  localparam logic [CFG_W-1:0] DEGRADE_TIMEOUT_RESET = 16'd200;
  localparam logic [CFG_W-1:0] RESTORE_TIME_RESET    = 16'd1000;

  localparam logic FUNC_POLL = 1'b0;
  localparam logic FUNC_TARE = 1'b1;

  typedef struct packed {
    logic                      func;
    logic [TIME_W-1:0]         now_ms;
    logic                      sample_present;
    logic                      has_yaw;
    logic signed [ANGLE_W-1:0] yaw_in;
    logic                      has_rate;
    logic signed [15:0]        rate_in;
    logic                      accel_present;
    logic signed [15:0]        accel_x_in;
    logic signed [15:0]        accel_y_in;
    logic signed [15:0]        accel_z_in;
  } req_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] yaw_out;
    logic                      yaw_is_valid;
    logic signed [15:0]        rate_out;
    logic signed [15:0]        accel_x_out;
    logic signed [15:0]        accel_y_out;
    logic signed [15:0]        accel_z_out;
    logic                      degraded_flag;
  } rsp_t;

  typedef struct packed {
    logic [CFG_W-1:0] degrade_timeout_ms;
    logic [CFG_W-1:0] restore_time_ms;
  } cfg_t;

endpackage

### rtl/iyts_cfg.sv
// configuration registers: staleness timeout and restore time
module iyts_cfg
  import iyts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.degrade_timeout_ms <= DEGRADE_TIMEOUT_RESET;
      cfg.restore_time_ms    <= RESTORE_TIME_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEGRADE_TIMEOUT: cfg.degrade_timeout_ms <= cfg_data;
        REG_RESTORE_TIME:    cfg.restore_time_ms    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### rtl/iyts_core.sv
// monitor state and its single-pass update for one item
module iyts_core
  import iyts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  req_t item,
  input  cfg_t cfg,
  output rsp_t result
);

  logic [ANGLE_W-1:0] yaw_reg, yaw_next;
  logic [ANGLE_W-1:0] tare_offset, tare_offset_next;
  logic               yaw_valid_reg, yaw_valid_next;
  logic [15:0]        rate_reg, rate_next;
  logic [15:0]        accel_x_reg, accel_x_next;
  logic [15:0]        accel_y_reg, accel_y_next;
  logic [15:0]        accel_z_reg, accel_z_next;
  logic               degraded_reg, degraded_next;
  logic [TIME_W-1:0]  last_yaw_time, last_yaw_time_next;
  logic [TIME_W-1:0]  last_healthy_time, last_healthy_time_next;

  logic [TIME_W-1:0] since;
  logic [TIME_W-1:0] healthy_for;
  logic              stale;
  logic              restored;

  always_comb begin
    yaw_next               = yaw_reg;
    tare_offset_next       = tare_offset;
    yaw_valid_next         = yaw_valid_reg;
    rate_next              = rate_reg;
    accel_x_next           = accel_x_reg;
    accel_y_next           = accel_y_reg;
    accel_z_next           = accel_z_reg;
    degraded_next          = degraded_reg;
    last_yaw_time_next     = last_yaw_time;
    last_healthy_time_next = last_healthy_time;

    if (item.func == FUNC_POLL && item.sample_present) begin
      if (item.has_yaw) begin
        yaw_next           = item.yaw_in - tare_offset;
        yaw_valid_next     = 1'b1;
        last_yaw_time_next = item.now_ms;
      end
      if (item.has_rate) rate_next = item.rate_in;
      if (item.accel_present) begin
        accel_x_next = item.accel_x_in;
        accel_y_next = item.accel_y_in;
        accel_z_next = item.accel_z_in;
      end
    end

    // staleness runs on the state as updated by this poll
    since       = yaw_valid_next ? item.now_ms - last_yaw_time_next : item.now_ms;
    healthy_for = item.now_ms - last_healthy_time;
    stale       = since > {{(TIME_W-CFG_W){1'b0}}, cfg.degrade_timeout_ms};
    restored    = healthy_for > {{(TIME_W-CFG_W){1'b0}}, cfg.restore_time_ms};

    if (item.func == FUNC_TARE) begin
      if (yaw_valid_reg) begin
        tare_offset_next = tare_offset + yaw_reg;
        yaw_next         = '0;
      end
    end else begin
      priority if (!degraded_reg && yaw_valid_next && stale) begin
        degraded_next          = 1'b1;
        last_healthy_time_next = item.now_ms;
      end else if (degraded_reg && !stale) begin
        if (restored) degraded_next = 1'b0;
      end else if (degraded_reg) begin
        last_healthy_time_next = item.now_ms;
      end else begin
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_reg           <= '0;
      tare_offset       <= '0;
      yaw_valid_reg     <= 1'b0;
      rate_reg          <= '0;
      accel_x_reg       <= '0;
      accel_y_reg       <= '0;
      accel_z_reg       <= '0;
      degraded_reg      <= 1'b0;
      last_yaw_time     <= '0;
      last_healthy_time <= '0;
    end else if (step) begin
      yaw_reg           <= yaw_next;
      tare_offset       <= tare_offset_next;
      yaw_valid_reg     <= yaw_valid_next;
      rate_reg          <= rate_next;
      accel_x_reg       <= accel_x_next;
      accel_y_reg       <= accel_y_next;
      accel_z_reg       <= accel_z_next;
      degraded_reg      <= degraded_next;
      last_yaw_time     <= last_yaw_time_next;
      last_healthy_time <= last_healthy_time_next;
    end
  end

  assign result.yaw_out       = yaw_next;
  assign result.yaw_is_valid  = yaw_valid_next;
  assign result.rate_out      = rate_next;
  assign result.accel_x_out   = accel_x_next;
  assign result.accel_y_out   = accel_y_next;
  assign result.accel_z_out   = accel_z_next;
  assign result.degraded_flag = degraded_next;

endmodule

### rtl/imu_yaw_tare_staleness_monitor.sv
// imu yaw tare and staleness monitor, top level with input and result registers
// the result passes through the input register and then the output register
// throughput: one item per cycle while the result side does not stall; the state update
// is one subtract/compare pass between the input register and the result register
// a stalled result holds the output register, and the input register fills behind it
// reset (rst, synchronous) clears all state and both stages; registers return to defaults
module imu_yaw_tare_staleness_monitor
  import iyts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t cfg;
  req_t item;
  logic item_valid;
  rsp_t result;
  logic out_take;
  logic step;

  iyts_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // result register can load when empty or being drained this cycle
  assign out_take  = !rsp_valid || !rsp_stall;
  assign step      = item_valid && out_take;
  assign req_stall = item_valid && !out_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!req_stall) begin
      item_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      item <= req;
    end
  end

  iyts_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_take) begin
      rsp_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rsp <= result;
    end
  end

endmodule

### rtl/iyts_checker.sv
// port-level checks for the monitor, bound to the top level
module iyts_checker
  import iyts_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // a held result keeps its transfer payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // with the result register empty the input side never stalls
  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> !req_stall)
    else $error("input stalled with empty output");

  // before any yaw the yaw reads zero and the flag stays low
  a_no_yaw_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.yaw_is_valid |-> rsp.yaw_out == 16'sd0 && !rsp.degraded_flag)
    else $error("yaw or flag set before first yaw");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind imu_yaw_tare_staleness_monitor iyts_checker u_iyts_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

### verif/tb_imu_yaw_tare_staleness_monitor.sv
// self-checking testbench for the imu yaw tare and staleness monitor
module tb_imu_yaw_tare_staleness_monitor;
  import iyts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    req_t item;
    bit   typed;
    rsp_t want;
  } step_row_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  req_t                 req = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  rsp_t                 rsp;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_DEGRADE_TIMEOUT;
  logic [CFG_W-1:0]     cfg_data = '0;

  // yaw tracker state kept alongside the block
  logic [15:0] m_yaw, m_offset, m_rate, m_ax, m_ay, m_az;
  logic        m_yaw_valid, m_degraded;
  logic [31:0] m_last_yaw_ms, m_last_healthy_ms;
  logic [15:0] m_timeout, m_restore;

  rsp_t        readings_q[$];
  step_row_t   directed_rows[$];
  int          err_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  // typed expectation travels with the payload it belongs to
  bit          row_typed = 1'b0;
  rsp_t        row_want = '0;

  // random stream state
  logic [31:0] clock_ms = '0;
  int          burst_left = 0;
  int          yaw_pct = 90;

  imu_yaw_tare_staleness_monitor u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  task automatic clear_tracker();
    m_yaw = '0;
    m_offset = '0;
    m_rate = '0;
    m_ax = '0;
    m_ay = '0;
    m_az = '0;
    m_yaw_valid = 1'b0;
    m_degraded = 1'b0;
    m_last_yaw_ms = '0;
    m_last_healthy_ms = '0;
    m_timeout = DEGRADE_TIMEOUT_RESET;
    m_restore = RESTORE_TIME_RESET;
  endtask

  task automatic update_staleness(input logic [31:0] now);
    logic [31:0] since;
    since = m_yaw_valid ? now - m_last_yaw_ms : now;
    if (!m_degraded && m_yaw_valid && since > {16'd0, m_timeout}) begin
      m_degraded = 1'b1;
      m_last_healthy_ms = now;
    end else if (m_degraded && since <= {16'd0, m_timeout}) begin
      if (now - m_last_healthy_ms > {16'd0, m_restore}) m_degraded = 1'b0;
    end else if (m_degraded) begin
      m_last_healthy_ms = now;
    end
  endtask

  task automatic track_yaw_state(input req_t r, output rsp_t o);
    if (r.func == FUNC_TARE) begin
      if (m_yaw_valid) begin
        m_offset = m_offset + m_yaw;
        m_yaw = '0;
      end
    end else begin
      if (r.sample_present) begin
        if (r.has_yaw) begin
          m_yaw = r.yaw_in - m_offset;
          m_yaw_valid = 1'b1;
          m_last_yaw_ms = r.now_ms;
        end
        if (r.has_rate) m_rate = r.rate_in;
        if (r.accel_present) begin
          m_ax = r.accel_x_in;
          m_ay = r.accel_y_in;
          m_az = r.accel_z_in;
        end
      end
      update_staleness(r.now_ms);
    end
    o = '{yaw_out: m_yaw, yaw_is_valid: m_yaw_valid, rate_out: m_rate,
          accel_x_out: m_ax, accel_y_out: m_ay, accel_z_out: m_az,
          degraded_flag: m_degraded};
  endtask

  always @(posedge clk) begin : scoreboard
    rsp_t pred;
    rsp_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (readings_q.size() == 0) begin
          if (err_count < 10) $display("result with nothing expected at %0t", $realtime);
          err_count++;
        end else begin
          want = readings_q.pop_front();
          if (rsp.yaw_out !== want.yaw_out || rsp.yaw_is_valid !== want.yaw_is_valid ||
              rsp.rate_out !== want.rate_out || rsp.accel_x_out !== want.accel_x_out ||
              rsp.accel_y_out !== want.accel_y_out ||
              rsp.accel_z_out !== want.accel_z_out ||
              rsp.degraded_flag !== want.degraded_flag) begin
            if (err_count < 10) begin
              $display("mismatch at %0t: exp yaw=%0d v=%0b rate=%0d acc=%0d/%0d/%0d deg=%0b",
                       $realtime, want.yaw_out, want.yaw_is_valid, want.rate_out,
                       want.accel_x_out, want.accel_y_out, want.accel_z_out,
                       want.degraded_flag);
              $display("                 got yaw=%0d v=%0b rate=%0d acc=%0d/%0d/%0d deg=%0b",
                       rsp.yaw_out, rsp.yaw_is_valid, rsp.rate_out, rsp.accel_x_out,
                       rsp.accel_y_out, rsp.accel_z_out, rsp.degraded_flag);
            end
            err_count++;
          end
        end
      end
      if (req_valid && !req_stall) begin
        track_yaw_state(req, pred);
        readings_q.push_back(row_typed ? row_want : pred);
      end
    end
  end

  always @(posedge clk) rsp_stall <= ($urandom_range(99) < recv_stall_pct);

  function automatic req_t poll_req(logic [31:0] t, logic sp, logic hy, logic [15:0] y,
                                    logic hr, logic [15:0] rt, logic ha,
                                    logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
    poll_req = '{func: FUNC_POLL, now_ms: t, sample_present: sp, has_yaw: hy, yaw_in: y,
                 has_rate: hr, rate_in: rt, accel_present: ha, accel_x_in: ax,
                 accel_y_in: ay, accel_z_in: az};
  endfunction

  // tare carries live-looking sample fields that must be ignored
  function automatic req_t tare_req(logic [31:0] t);
    tare_req = poll_req(t, 1'b1, 1'b1, 16'h7abc, 1'b1, 16'h1111, 1'b1,
                        16'h2222, 16'h3333, 16'h4444);
    tare_req.func = FUNC_TARE;
  endfunction

  function automatic rsp_t reading(logic [15:0] y, logic v, logic [15:0] rt,
                                   logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                                   logic d);
    reading = '{yaw_out: y, yaw_is_valid: v, rate_out: rt, accel_x_out: ax,
                accel_y_out: ay, accel_z_out: az, degraded_flag: d};
  endfunction

  task automatic add_row(input req_t r, input bit typed, input rsp_t want);
    step_row_t row;
    row.item = r;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  task automatic send_item(input req_t r, input bit typed, input rsp_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    row_typed <= typed;
    row_want <= want;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (readings_q.size() != 0) @(posedge clk);
  endtask

  task automatic load_thresholds(input logic [15:0] tmo, input logic [15:0] rest);
    cfg_we <= 1'b1;
    cfg_index <= REG_DEGRADE_TIMEOUT;
    cfg_data <= tmo;
    @(posedge clk);
    cfg_index <= REG_RESTORE_TIME;
    cfg_data <= rest;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_timeout = tmo;
    m_restore = rest;
  endtask

  // bursts of healthy or starved yaw flow, time steps scaled to the thresholds
  task automatic make_random_item(output req_t r);
    logic [31:0] span;
    int          pick;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 4);
      yaw_pct = $urandom_range(1) ? 90 : 15;
    end
    burst_left--;
    span = (m_timeout > m_restore ? m_timeout : m_restore) + 32'd2;
    pick = $urandom_range(99);
    if (pick < 45) clock_ms += $urandom_range(span / 8 + 1);
    else if (pick < 75) clock_ms += $urandom_range(span + span / 2);
    else if (pick < 85) clock_ms += m_timeout + $urandom_range(1);
    else if (pick < 92) clock_ms += m_restore + $urandom_range(1);
    else if (pick < 96) clock_ms += $urandom;
    else clock_ms -= $urandom_range(span, 1);
    r.func = ($urandom_range(99) < 8) ? FUNC_TARE : FUNC_POLL;
    r.now_ms = clock_ms;
    r.sample_present = ($urandom_range(99) < 85);
    r.has_yaw = ($urandom_range(99) < yaw_pct);
    r.yaw_in = 16'($urandom);
    r.has_rate = 1'($urandom_range(1));
    r.rate_in = 16'($urandom);
    r.accel_present = 1'($urandom_range(1));
    r.accel_x_in = 16'($urandom);
    r.accel_y_in = 16'($urandom);
    r.accel_z_in = 16'($urandom);
  endtask

  task automatic run_phase(input logic [15:0] tmo, input logic [15:0] rest, input int idle,
                           input int stall, input int n_items, input int pause_at);
    req_t r;
    wait_drained();
    load_thresholds(tmo, rest);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n_items; i++) begin
      if (i == pause_at) wait_drained();
      make_random_item(r);
      send_item(r, 1'b0, '0);
    end
  endtask

  initial begin
    clear_tracker();
    // defaults after reset: timeout 200, restore 1000
    add_row(tare_req(32'd0), 1'b1, reading(16'h0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0));
    add_row(poll_req(32'd1000, 1'b0, 1'b1, 16'h1234, 1'b1, 16'h2222, 1'b1, 16'h3333,
                     16'h4444, 16'h5555), 1'b1,
            reading(16'h0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0));
    add_row(poll_req(32'd0, 1'b1, 1'b1, 16'h7fff, 1'b1, 16'h8000, 1'b1, 16'h8000,
                     16'h7fff, 16'hffff), 1'b1,
            reading(16'h7fff, 1'b1, 16'h8000, 16'h8000, 16'h7fff, 16'hffff, 1'b0));
    add_row(poll_req(32'd200, 1'b1, 1'b0, 16'h0, 1'b1, 16'h7fff, 1'b0, 16'h0, 16'h0,
                     16'h0), 1'b1,
            reading(16'h7fff, 1'b1, 16'h7fff, 16'h8000, 16'h7fff, 16'hffff, 1'b0));
    add_row(poll_req(32'd201, 1'b0, 1'b1, 16'h1, 1'b1, 16'h1, 1'b1, 16'h1, 16'h1, 16'h1),
            1'b1, reading(16'h7fff, 1'b1, 16'h7fff, 16'h8000, 16'h7fff, 16'hffff, 1'b1));
    add_row(tare_req(32'd202), 1'b1,
            reading(16'h0, 1'b1, 16'h7fff, 16'h8000, 16'h7fff, 16'hffff, 1'b1));
    add_row(poll_req(32'd300, 1'b1, 1'b1, 16'h8000, 1'b0, 16'h0, 1'b0, 16'h0, 16'h0,
                     16'h0), 1'b0, '0);
    add_row(poll_req(32'd1201, 1'b1, 1'b1, 16'h0, 1'b0, 16'h0, 1'b0, 16'h0, 16'h0, 16'h0),
            1'b0, '0);
    add_row(poll_req(32'd1202, 1'b1, 1'b1, 16'd100, 1'b0, 16'h0, 1'b0, 16'h0, 16'h0,
                     16'h0), 1'b0, '0);
    // timestamp wraps through zero
    add_row(poll_req(32'hffff_ffff, 1'b0, 1'b0, 16'h0, 1'b0, 16'h0, 1'b0, 16'h0, 16'h0,
                     16'h0), 1'b0, '0);
    add_row(poll_req(32'd0, 1'b1, 1'b1, 16'h4000, 1'b0, 16'h0, 1'b0, 16'h0, 16'h0, 16'h0),
            1'b0, '0);
    add_row(poll_req(32'd5000, 1'b1, 1'b0, 16'h0, 1'b1, 16'h0001, 1'b0, 16'h0, 16'h0,
                     16'h0), 1'b0, '0);
    add_row(poll_req(32'd5100, 1'b1, 1'b1, 16'hc000, 1'b0, 16'h0, 1'b0, 16'h0, 16'h0,
                     16'h0), 1'b0, '0);
    // time running backwards
    add_row(poll_req(32'd4000, 1'b1, 1'b1, 16'h0123, 1'b0, 16'h0, 1'b0, 16'h0, 16'h0,
                     16'h0), 1'b0, '0);
    add_row(tare_req(32'd4001), 1'b0, '0);
    add_row(tare_req(32'd4002), 1'b0, '0);
    add_row(poll_req(32'd4003, 1'b1, 1'b0, 16'h0, 1'b0, 16'h0, 1'b1, 16'h5555, 16'haaaa,
                     16'h0), 1'b0, '0);
    add_row(poll_req(32'd4004, 1'b1, 1'b0, 16'hffff, 1'b0, 16'hffff, 1'b0, 16'hffff,
                     16'hffff, 16'hffff), 1'b0, '0);
    add_row(poll_req(32'd4005, 1'b1, 1'b1, 16'hffff, 1'b1, 16'hffff, 1'b1, 16'hffff,
                     16'hffff, 16'hffff), 1'b0, '0);
    add_row(poll_req(32'd4205, 1'b0, 1'b0, 16'h0, 1'b0, 16'h0, 1'b0, 16'h0, 16'h0, 16'h0),
            1'b0, '0);
    add_row(poll_req(32'd4206, 1'b0, 1'b0, 16'h0, 1'b0, 16'h0, 1'b0, 16'h0, 16'h0, 16'h0),
            1'b0, '0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    clock_ms = 32'd10000;
    run_phase(16'd50, 16'd120, 0, 0, 250, 100);
    run_phase(16'd0, 16'd0, 50, 0, 200, -1);
    run_phase(16'hffff, 16'hffff, 0, 50, 200, -1);
    run_phase(16'($urandom_range(400, 1)), 16'($urandom_range(1500, 1)), 9, 9, 250, -1);
    run_phase(16'd300, 16'd30, 0, 0, 200, 80);
    run_phase(16'($urandom), 16'($urandom), 9, 9, 300, -1);

    wait_drained();
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
